// File: sv/u16u8_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package u16u8_pkg;

    // Default configuration and sizing.
    localparam int unsigned MAX_UNITS_DEFAULT   = 32;
    localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;
    localparam logic [7:0]  CAPACITY_RESET      = 8'd64;

    // UTF-16 surrogate ranges.
    localparam logic [15:0] HIGH_FIRST = 16'hD800;
    localparam logic [15:0] HIGH_LAST  = 16'hDBFF;
    localparam logic [15:0] LOW_FIRST  = 16'hDC00;
    localparam logic [15:0] LOW_LAST   = 16'hDFFF;

    // Code points and UTF-8 length boundaries.
    localparam logic [20:0] REPLACEMENT = 21'h00FFFD;
    localparam logic [20:0] PLANE1_BASE = 21'h010000;
    localparam logic [20:0] LIMIT_1BYTE = 21'h000080;
    localparam logic [20:0] LIMIT_2BYTE = 21'h000800;

    // UTF-8 lead and continuation markers.
    localparam logic [7:0] LEAD_2     = 8'hC0;
    localparam logic [7:0] LEAD_3     = 8'hE0;
    localparam logic [7:0] LEAD_4     = 8'hF0;
    localparam logic [7:0] CONT       = 8'h80;
    localparam logic [5:0] CONT_MASK  = 6'h3F;

    // One queued job: the bytes that one input item produces.
    typedef struct packed {
        logic [20:0] cp0;
        logic [2:0]  len0;
        logic        use0;
        logic [20:0] cp1;
        logic [2:0]  len1;
        logic        use1;
        logic        nul;
    } job_t;

    // Number of UTF-8 bytes needed for a code point.
    function automatic logic [2:0] cp_len(input logic [20:0] cp);
        logic [2:0] n;
        begin
            if (cp < LIMIT_1BYTE) begin
                n = 3'd1;
            end else if (cp < LIMIT_2BYTE) begin
                n = 3'd2;
            end else if (cp < PLANE1_BASE) begin
                n = 3'd3;
            end else begin
                n = 3'd4;
            end
            return n;
        end
    endfunction

    // Byte number idx of the UTF-8 encoding of cp, which is len bytes long.
    function automatic logic [7:0] enc_byte(input logic [20:0] cp,
                                            input logic [2:0]  len,
                                            input logic [1:0]  idx);
        logic [7:0] b;
        begin
            b = 8'h00;
            case (len)
                3'd1: begin
                    b = {1'b0, cp[6:0]};
                end
                3'd2: begin
                    if (idx == 2'd0) begin
                        b = LEAD_2 | {3'b000, cp[10:6]};
                    end else begin
                        b = CONT | {2'b00, cp[5:0] & CONT_MASK};
                    end
                end
                3'd3: begin
                    case (idx)
                        2'd0:    b = LEAD_3 | {4'b0000, cp[15:12]};
                        2'd1:    b = CONT | {2'b00, cp[11:6]};
                        default: b = CONT | {2'b00, cp[5:0]};
                    endcase
                end
                default: begin
                    case (idx)
                        2'd0:    b = LEAD_4 | {5'b00000, cp[20:18]};
                        2'd1:    b = CONT | {2'b00, cp[17:12]};
                        2'd2:    b = CONT | {2'b00, cp[11:6]};
                        default: b = CONT | {2'b00, cp[5:0]};
                    endcase
                end
            endcase
            return b;
        end
    endfunction

endpackage

`default_nettype wire

// File: sv/utf16le_to_utf8_transcoder.sv
`timescale 1ns / 1ps
`default_nettype none

// UTF-16LE to UTF-8 name transcoder. Each input transfer carries at most one
// UTF-16 code unit plus an end-of-name flag; the block answers with the UTF-8
// bytes that the unit completes, one byte per output transfer. A high
// surrogate is held until the next unit; a valid pair gives a 4-byte code
// point and any unpaired surrogate becomes U+FFFD. A character is written only
// if its bytes plus the closing NUL still fit in output_capacity (written on
// the cfg channel, reset value 64), and only the first MAX_UNITS units of a
// name are used. The end of a name flushes a held surrogate as U+FFFD and ends
// with a NUL byte that has m_final_byte set. The front end classifies each
// unit and makes all fit decisions in the cycle it is accepted, so it takes
// one transfer per cycle while the job queue (QUEUE_DEPTH entries) has room.
// The back end sends one byte per cycle while m_ready is high, from a
// registered output. An item yields one to three bytes for a typical unit,
// up to seven for a flushed surrogate at the end of a name, and none for a
// character that does not fit. Capacity should only be written while the
// block is idle; cfg_ready is always high.

module utf16le_to_utf8_transcoder #(
    parameter int unsigned MAX_UNITS   = u16u8_pkg::MAX_UNITS_DEFAULT,
    parameter int unsigned QUEUE_DEPTH = u16u8_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    // Configuration write channel: output_capacity.
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_data,

    // Input channel: one UTF-16 code unit per transfer.
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [15:0] s_code_unit,
    input  wire logic        s_has_unit,
    input  wire logic        s_end_of_name,

    // Output channel: one UTF-8 byte per transfer.
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_out_byte,
    output logic             m_final_byte
);

    logic [7:0]       capacity_reg, capacity_next;
    logic             q_push, q_ready, q_pop, q_head_valid;
    u16u8_pkg::job_t  q_push_job, q_head_job;

    // The capacity register accepts a write in every cycle.
    assign cfg_ready = 1'b1;

    always_comb begin
        capacity_next = capacity_reg;
        if (cfg_valid && cfg_ready) begin
            capacity_next = cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= u16u8_pkg::CAPACITY_RESET;
        end else begin
            capacity_reg <= capacity_next;
        end
    end

    // Front end: surrogate pairing, unit limit and fit checks.
    u16u8_front #(
        .MAX_UNITS (MAX_UNITS)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .capacity      (capacity_reg),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_code_unit   (s_code_unit),
        .s_has_unit    (s_has_unit),
        .s_end_of_name (s_end_of_name),
        .q_ready       (q_ready),
        .q_push        (q_push),
        .q_job         (q_push_job)
    );

    // Job queue that decouples the front end from the byte sender.
    u16u8_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_job   (q_push_job),
        .push_ready (q_ready),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_job   (q_head_job)
    );

    // Back end: expands each job into UTF-8 bytes and the closing NUL.
    u16u8_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .head_valid   (q_head_valid),
        .head_job     (q_head_job),
        .pop          (q_pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_byte   (m_out_byte),
        .m_final_byte (m_final_byte)
    );

endmodule

`default_nettype wire

// File: sv/u16u8_front.sv
`timescale 1ns / 1ps
`default_nettype none

module u16u8_front #(
    parameter int unsigned MAX_UNITS = u16u8_pkg::MAX_UNITS_DEFAULT
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic [7:0]        capacity,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [15:0]       s_code_unit,
    input  wire logic              s_has_unit,
    input  wire logic              s_end_of_name,
    input  wire logic              q_ready,
    output logic                   q_push,
    output u16u8_pkg::job_t        q_job
);

    localparam int unsigned UW = $clog2(MAX_UNITS + 1);
    localparam logic [UW-1:0] UNIT_LIMIT = UW'(MAX_UNITS);

    logic [9:0]    held_high_reg, held_high_next;
    logic          held_valid_reg, held_valid_next;
    logic [7:0]    bytes_written_reg, bytes_written_next;
    logic [UW-1:0] units_taken_reg, units_taken_next;

    logic          take, is_high, is_low, pair_done;
    logic          held_mid;
    logic [9:0]    held_high_mid;
    logic [20:0]   cp0, cp1;
    logic          want0, want1, fit0, fit1;
    logic [2:0]    len0, len1;
    logic [7:0]    bw_mid;
    logic          accept;

    assign s_ready = q_ready;
    assign accept  = s_valid && s_ready;

    always_comb begin
        take      = s_has_unit && (units_taken_reg < UNIT_LIMIT);
        is_high   = s_code_unit inside {[u16u8_pkg::HIGH_FIRST:u16u8_pkg::HIGH_LAST]};
        is_low    = s_code_unit inside {[u16u8_pkg::LOW_FIRST:u16u8_pkg::LOW_LAST]};
        pair_done = take && held_valid_reg && is_low;

        // First character: whatever the held high surrogate turns into.
        want0 = take && held_valid_reg;
        if (is_low) begin
            cp0 = u16u8_pkg::PLANE1_BASE + {1'b0, held_high_reg, s_code_unit[9:0]};
        end else begin
            cp0 = u16u8_pkg::REPLACEMENT;
        end

        // Surrogate state after the unit has been looked at.
        if (take) begin
            held_mid = !pair_done && is_high;
        end else begin
            held_mid = held_valid_reg;
        end
        held_high_mid = (take && !pair_done && is_high) ? s_code_unit[9:0] : held_high_reg;

        // Second character: the unit itself, or the flush at the end of the name.
        if (take && !pair_done && !is_high) begin
            want1 = 1'b1;
            cp1   = is_low ? u16u8_pkg::REPLACEMENT : {5'b00000, s_code_unit};
        end else begin
            want1 = s_end_of_name && held_mid;
            cp1   = u16u8_pkg::REPLACEMENT;
        end

        len0   = u16u8_pkg::cp_len(cp0);
        len1   = u16u8_pkg::cp_len(cp1);
        fit0   = want0 && (({1'b0, bytes_written_reg} + {6'b000000, len0}) < {1'b0, capacity});
        bw_mid = fit0 ? (bytes_written_reg + {5'b00000, len0}) : bytes_written_reg;
        fit1   = want1 && (({1'b0, bw_mid} + {6'b000000, len1}) < {1'b0, capacity});

        q_job.cp0  = cp0;
        q_job.len0 = len0;
        q_job.use0 = fit0;
        q_job.cp1  = cp1;
        q_job.len1 = len1;
        q_job.use1 = fit1;
        q_job.nul  = s_end_of_name;
        q_push     = accept && (fit0 || fit1 || s_end_of_name);

        held_high_next     = held_high_reg;
        held_valid_next    = held_valid_reg;
        bytes_written_next = bytes_written_reg;
        units_taken_next   = units_taken_reg;
        if (accept) begin
            if (s_end_of_name) begin
                held_high_next     = 10'd0;
                held_valid_next    = 1'b0;
                bytes_written_next = 8'd0;
                units_taken_next   = '0;
            end else begin
                held_high_next     = held_high_mid;
                held_valid_next    = held_mid;
                bytes_written_next = fit1 ? (bw_mid + {5'b00000, len1}) : bw_mid;
                if (take) begin
                    units_taken_next = units_taken_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_high_reg     <= 10'd0;
            held_valid_reg    <= 1'b0;
            bytes_written_reg <= 8'd0;
            units_taken_reg   <= '0;
        end else begin
            held_high_reg     <= held_high_next;
            held_valid_reg    <= held_valid_next;
            bytes_written_reg <= bytes_written_next;
            units_taken_reg   <= units_taken_next;
        end
    end

endmodule

`default_nettype wire

// File: sv/u16u8_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module u16u8_queue #(
    parameter int unsigned DEPTH = u16u8_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire u16u8_pkg::job_t  push_job,
    output logic                  push_ready,
    input  wire logic             pop,
    output logic                  head_valid,
    output u16u8_pkg::job_t       head_job
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    u16u8_pkg::job_t slots_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign push_ready = (count_reg != FULL_COUNT);
    assign head_valid = (count_reg != '0);
    assign head_job   = slots_reg[rd_ptr_reg];

    always_comb begin
        do_push     = push && push_ready;
        do_pop      = pop && head_valid;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slots_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// File: sv/u16u8_back.sv
`timescale 1ns / 1ps
`default_nettype none

module u16u8_back (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             head_valid,
    input  wire u16u8_pkg::job_t  head_job,
    output logic                  pop,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic [7:0]            m_out_byte,
    output logic                  m_final_byte
);

    localparam logic [1:0] PH_CHAR0 = 2'd0;
    localparam logic [1:0] PH_CHAR1 = 2'd1;
    localparam logic [1:0] PH_NUL   = 2'd2;

    logic [1:0] phase_reg, phase_next;
    logic [1:0] idx_reg, idx_next;
    logic       m_valid_reg, m_valid_next;
    logic [7:0] m_out_byte_reg, m_out_byte_next;
    logic       m_final_byte_reg, m_final_byte_next;

    logic [1:0]  cur;
    logic [20:0] cur_cp;
    logic [2:0]  cur_len;
    logic        last_in_char, more, slot_free, load;

    assign m_valid      = m_valid_reg;
    assign m_out_byte   = m_out_byte_reg;
    assign m_final_byte = m_final_byte_reg;

    always_comb begin
        // Skip the characters that did not fit.
        if (phase_reg == PH_CHAR0 && head_job.use0) begin
            cur = PH_CHAR0;
        end else if (phase_reg != PH_NUL && head_job.use1) begin
            cur = PH_CHAR1;
        end else begin
            cur = PH_NUL;
        end
        cur_cp  = (cur == PH_CHAR0) ? head_job.cp0 : head_job.cp1;
        cur_len = (cur == PH_CHAR0) ? head_job.len0 : head_job.len1;

        last_in_char = (cur == PH_NUL) || (({1'b0, idx_reg} + 3'd1) == cur_len);
        case (cur)
            PH_CHAR0: more = !last_in_char || head_job.use1 || head_job.nul;
            PH_CHAR1: more = !last_in_char || head_job.nul;
            default:  more = 1'b0;
        endcase

        slot_free = !m_valid_reg || m_ready;
        load      = slot_free && head_valid;
        pop       = load && !more;

        phase_next        = phase_reg;
        idx_next          = idx_reg;
        m_valid_next      = m_valid_reg;
        m_out_byte_next   = m_out_byte_reg;
        m_final_byte_next = m_final_byte_reg;
        if (slot_free) begin
            m_valid_next = head_valid;
        end
        if (load) begin
            if (cur == PH_NUL) begin
                m_out_byte_next   = 8'h00;
                m_final_byte_next = 1'b1;
            end else begin
                m_out_byte_next   = u16u8_pkg::enc_byte(cur_cp, cur_len, idx_reg);
                m_final_byte_next = 1'b0;
            end
            if (!more) begin
                phase_next = PH_CHAR0;
                idx_next   = 2'd0;
            end else if (last_in_char) begin
                phase_next = cur + 2'd1;
                idx_next   = 2'd0;
            end else begin
                phase_next = cur;
                idx_next   = idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_CHAR0;
            idx_reg     <= 2'd0;
            m_valid_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_out_byte_reg   <= m_out_byte_next;
        m_final_byte_reg <= m_final_byte_next;
    end

endmodule

`default_nettype wire

// File: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    // The unit limit of a name, passed to the block so that both sides agree.
    localparam int unsigned NAME_UNIT_LIMIT = u16u8_pkg::MAX_UNITS_DEFAULT;

    // Cycles allowed for bytes still inside the block after the last expected
    // one has left. The job queue holds four items of up to seven bytes each.
    localparam int DRAIN_CYCLES = 40;

    // Cycles with no transfer on any channel before the run is declared hung.
    localparam int STALL_LIMIT = 2000;

    // Random input items per capacity setting; twelve settings in all.
    localparam int ITEMS_PER_SETTING = 22;

    // A row of the directed table either writes the capacity or sends one item.
    // For an item, the expected bytes are either typed into the row or left
    // to the predictor.
    typedef enum logic [1:0] {
        ROW_LIT,
        ROW_PRED,
        ROW_CFG
    } row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        logic [15:0] unit;
        logic        has;
        logic        eon;
        logic [2:0]  n_bytes;
        logic [55:0] bytes;
    } row_t;

    // Expected bytes are right aligned: the first byte out is the highest one.
    localparam int DIRECTED_ROWS = 29;
    localparam row_t DIRECTED [DIRECTED_ROWS] = '{
        // Length boundaries of one, two and three byte characters.
        '{ROW_LIT,  16'h0041, 1'b1, 1'b0, 3'd1, 56'h41},
        '{ROW_LIT,  16'h0000, 1'b1, 1'b0, 3'd1, 56'h00},
        '{ROW_LIT,  16'h007F, 1'b1, 1'b0, 3'd1, 56'h7F},
        '{ROW_LIT,  16'h0080, 1'b1, 1'b0, 3'd2, 56'hC280},
        '{ROW_LIT,  16'h07FF, 1'b1, 1'b0, 3'd2, 56'hDFBF},
        '{ROW_LIT,  16'h0800, 1'b1, 1'b0, 3'd3, 56'hE0A080},
        '{ROW_LIT,  16'hFFFF, 1'b1, 1'b0, 3'd3, 56'hEFBFBF},
        // The lowest and the highest surrogate pair.
        '{ROW_LIT,  16'hD800, 1'b1, 1'b0, 3'd0, 56'h0},
        '{ROW_LIT,  16'hDC00, 1'b1, 1'b0, 3'd4, 56'hF0908080},
        '{ROW_PRED, 16'hDBFF, 1'b1, 1'b0, 3'd0, 56'h0},
        '{ROW_PRED, 16'hDFFF, 1'b1, 1'b0, 3'd0, 56'h0},
        // A lone low surrogate, then a high surrogate followed by another one.
        '{ROW_LIT,  16'hDC00, 1'b1, 1'b0, 3'd3, 56'hEFBFBD},
        '{ROW_LIT,  16'hD800, 1'b1, 1'b0, 3'd0, 56'h0},
        '{ROW_LIT,  16'hDBFF, 1'b1, 1'b0, 3'd3, 56'hEFBFBD},
        // An end marker alone flushes the held surrogate before the NUL.
        '{ROW_LIT,  16'h0000, 1'b0, 1'b1, 3'd4, 56'hEFBFBD00},
        // Neither a unit nor an end marker: nothing comes out.
        '{ROW_LIT,  16'h1234, 1'b0, 1'b0, 3'd0, 56'h0},
        // A unit that also closes the name is handled before the flush.
        '{ROW_LIT,  16'hD801, 1'b1, 1'b1, 3'd4, 56'hEFBFBD00},
        '{ROW_LIT,  16'h0000, 1'b0, 1'b1, 3'd1, 56'h00},
        // The longest answer to one item: two replacements and the NUL.
        '{ROW_LIT,  16'hD800, 1'b1, 1'b0, 3'd0, 56'h0},
        '{ROW_LIT,  16'hD800, 1'b1, 1'b1, 3'd7, 56'hEFBFBDEFBFBD00},
        // With no room at all only the NUL is written.
        '{ROW_CFG,  16'h0000, 1'b0, 1'b0, 3'd0, 56'h0},
        '{ROW_LIT,  16'h0041, 1'b1, 1'b1, 3'd1, 56'h00},
        // A character that does not fit is dropped, a shorter one still fits.
        '{ROW_CFG,  16'h0003, 1'b0, 1'b0, 3'd0, 56'h0},
        '{ROW_LIT,  16'h0041, 1'b1, 1'b0, 3'd1, 56'h41},
        '{ROW_LIT,  16'h0080, 1'b1, 1'b0, 3'd0, 56'h0},
        '{ROW_LIT,  16'h0042, 1'b1, 1'b0, 3'd1, 56'h42},
        // The capacity grows in the middle of the name.
        '{ROW_CFG,  16'h00FF, 1'b0, 1'b0, 3'd0, 56'h0},
        '{ROW_PRED, 16'h0800, 1'b1, 1'b0, 3'd0, 56'h0},
        '{ROW_LIT,  16'h0000, 1'b0, 1'b1, 3'd1, 56'h00}
    };

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } utf8_byte_t;

    // Clock, reset and block ports. Every input starts at a known value.
    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        cfg_valid     = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_data      = 8'h00;
    logic        s_valid       = 1'b0;
    logic        s_ready;
    logic [15:0] s_code_unit   = 16'h0000;
    logic        s_has_unit    = 1'b0;
    logic        s_end_of_name = 1'b0;
    logic        m_valid;
    logic        m_ready       = 1'b0;
    logic [7:0]  m_out_byte;
    logic        m_final_byte;

    // Predictor state: the capacity and the progress through the current name.
    logic [7:0]  capacity    = u16u8_pkg::CAPACITY_RESET;
    logic [9:0]  held_bits   = 10'd0;
    logic        high_held   = 1'b0;
    logic [7:0]  name_bytes  = 8'd0;
    int          units_taken = 0;

    // Bytes that the block still owes, oldest first.
    utf8_byte_t  utf8_expected [$];

    int          mismatches    = 0;
    int          quiet_cycles  = 0;
    int          items_sent    = 0;
    int          units_left    = 0;
    int          src_idle_pct  = 0;
    int          sink_idle_pct = 0;

    utf16le_to_utf8_transcoder #(
        .MAX_UNITS     (NAME_UNIT_LIMIT)
    ) DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_code_unit   (s_code_unit),
        .s_has_unit    (s_has_unit),
        .s_end_of_name (s_end_of_name),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_final_byte  (m_final_byte)
    );

    // 2 ns clock period.
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Encodes one code point and appends its bytes if they and the closing NUL
    // still fit within the capacity. The sequence is built right aligned.
    task automatic append_char(input logic [20:0] cp, inout logic [55:0] vec,
                               inout int n);
        logic [31:0] seq;
        int          len;
        begin
            if (cp < u16u8_pkg::LIMIT_1BYTE) begin
                seq = {24'd0, 1'b0, cp[6:0]};
                len = 1;
            end else if (cp < u16u8_pkg::LIMIT_2BYTE) begin
                seq = {16'd0, u16u8_pkg::LEAD_2 | {3'd0, cp[10:6]},
                       u16u8_pkg::CONT | {2'd0, cp[5:0]}};
                len = 2;
            end else if (cp < u16u8_pkg::PLANE1_BASE) begin
                seq = {8'd0, u16u8_pkg::LEAD_3 | {4'd0, cp[15:12]},
                       u16u8_pkg::CONT | {2'd0, cp[11:6]},
                       u16u8_pkg::CONT | {2'd0, cp[5:0]}};
                len = 3;
            end else begin
                seq = {u16u8_pkg::LEAD_4 | {5'd0, cp[20:18]},
                       u16u8_pkg::CONT | {2'd0, cp[17:12]},
                       u16u8_pkg::CONT | {2'd0, cp[11:6]},
                       u16u8_pkg::CONT | {2'd0, cp[5:0]}};
                len = 4;
            end
            if (int'(name_bytes) + len < int'(capacity)) begin
                for (int k = len - 1; k >= 0; k--) begin
                    vec = {vec[47:0], seq[8*k +: 8]};
                    n++;
                end
                name_bytes = name_bytes + 8'(len);
            end
        end
    endtask

    // Works out the bytes that one accepted item causes and advances the
    // predictor state. The unit is handled first, then the end of the name.
    task automatic transcode(input logic [15:0] cu, input logic hu, input logic en,
                             output logic [55:0] vec, output int n);
        logic paired;
        begin
            vec    = '0;
            n      = 0;
            paired = 1'b0;
            if (hu && units_taken < NAME_UNIT_LIMIT) begin
                units_taken++;
                if (high_held) begin
                    high_held = 1'b0;
                    if (cu >= u16u8_pkg::LOW_FIRST && cu <= u16u8_pkg::LOW_LAST) begin
                        append_char(u16u8_pkg::PLANE1_BASE + {1'b0, held_bits, cu[9:0]},
                                    vec, n);
                        paired = 1'b1;
                    end else begin
                        append_char(u16u8_pkg::REPLACEMENT, vec, n);
                    end
                end
                if (!paired) begin
                    if (cu >= u16u8_pkg::HIGH_FIRST && cu <= u16u8_pkg::HIGH_LAST) begin
                        held_bits = cu[9:0];
                        high_held = 1'b1;
                    end else if (cu >= u16u8_pkg::LOW_FIRST && cu <= u16u8_pkg::LOW_LAST) begin
                        append_char(u16u8_pkg::REPLACEMENT, vec, n);
                    end else begin
                        append_char({5'd0, cu}, vec, n);
                    end
                end
            end
            if (en) begin
                if (high_held) begin
                    append_char(u16u8_pkg::REPLACEMENT, vec, n);
                end
                vec         = {vec[47:0], 8'h00};
                n++;
                high_held   = 1'b0;
                held_bits   = 10'd0;
                name_bytes  = 8'd0;
                units_taken = 0;
            end
        end
    endtask

    // Offers one item after a random gap and waits for its transfer. At the
    // accepting edge the expected bytes are queued, either from the predictor
    // or, for typed table rows, from the row itself.
    task automatic push_item(input logic [15:0] cu, input logic hu, input logic en,
                             input logic use_lit, input logic [2:0] lit_n,
                             input logic [55:0] lit_bytes);
        logic [55:0] vec;
        int          n;
        utf8_byte_t  entry;
        begin
            if ($urandom_range(0, 99) < src_idle_pct) begin
                s_valid <= 1'b0;
                do @(posedge aclk); while ($urandom_range(0, 99) < src_idle_pct);
            end
            s_valid       <= 1'b1;
            s_code_unit   <= cu;
            s_has_unit    <= hu;
            s_end_of_name <= en;
            do @(posedge aclk); while (!s_ready);
            transcode(cu, hu, en, vec, n);
            if (use_lit) begin
                vec = lit_bytes;
                n   = int'(lit_n);
            end
            for (int k = n - 1; k >= 0; k--) begin
                entry.value = vec[8*k +: 8];
                entry.last  = en && (k == 0);
                utf8_expected.push_back(entry);
            end
        end
    endtask

    // Writes the capacity once the block has gone idle: the input side is
    // quiet, every expected byte has arrived and the queue has drained.
    task automatic write_capacity(input logic [7:0] value);
        begin
            s_valid <= 1'b0;
            while (utf8_expected.size() != 0) @(posedge aclk);
            repeat (DRAIN_CYCLES) @(posedge aclk);
            cfg_valid <= 1'b1;
            cfg_data  <= value;
            do @(posedge aclk); while (!cfg_ready);
            cfg_valid <= 1'b0;
            capacity = value;
        end
    endtask

    // Most names are short; some run past the unit limit.
    function automatic int next_name_length();
        begin
            if ($urandom_range(0, 99) < 15) begin
                return int'($urandom_range(NAME_UNIT_LIMIT + 1, NAME_UNIT_LIMIT + 8));
            end
            return int'($urandom_range(1, 12));
        end
    endfunction

    // Sends one unit of the current name. The last unit of a name sometimes
    // carries the end marker itself, and then a new name begins.
    task automatic send_unit(input logic [15:0] cu);
        logic close_name;
        begin
            units_left--;
            close_name = (units_left == 0) && ($urandom_range(0, 2) == 0);
            push_item(cu, 1'b1, close_name, 1'b0, 3'd0, '0);
            items_sent++;
            if (close_name) begin
                units_left = next_name_length();
            end
        end
    endtask

    // Random names: mostly well-formed characters and surrogate pairs, with
    // some lone surrogates, raw 16-bit noise and items that carry nothing.
    task automatic stream_names(input int count);
        int target;
        int pick;
        begin
            target = items_sent + count;
            while (items_sent < target) begin
                if (units_left == 0) begin
                    push_item(16'($urandom_range(0, 16'hFFFF)), 1'b0, 1'b1, 1'b0, 3'd0, '0);
                    items_sent++;
                    units_left = next_name_length();
                end else begin
                    pick = $urandom_range(0, 99);
                    if (pick < 4) begin
                        // Ignored by the block, so it is not counted.
                        push_item(16'($urandom_range(0, 16'hFFFF)), 1'b0, 1'b0, 1'b0,
                                  3'd0, '0);
                    end else if (pick < 30) begin
                        send_unit(16'($urandom_range(0, 16'h007F)));
                    end else if (pick < 45) begin
                        send_unit(16'($urandom_range(16'h0080, 16'h07FF)));
                    end else if (pick < 62) begin
                        if ($urandom_range(0, 1) == 0) begin
                            send_unit(16'($urandom_range(16'h0800, 16'hD7FF)));
                        end else begin
                            send_unit(16'($urandom_range(16'hE000, 16'hFFFF)));
                        end
                    end else if (pick < 82 && units_left >= 2) begin
                        send_unit(u16u8_pkg::HIGH_FIRST + 16'($urandom_range(0, 1023)));
                        send_unit(u16u8_pkg::LOW_FIRST + 16'($urandom_range(0, 1023)));
                    end else if (pick < 88) begin
                        send_unit(u16u8_pkg::HIGH_FIRST + 16'($urandom_range(0, 1023)));
                    end else if (pick < 93) begin
                        send_unit(u16u8_pkg::LOW_FIRST + 16'($urandom_range(0, 1023)));
                    end else begin
                        send_unit(16'($urandom_range(0, 16'hFFFF)));
                    end
                end
            end
        end
    endtask

    // The receiver drops ready at random, at the rate of the current phase.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end

    // Each byte transfer is checked against the oldest expected byte.
    always @(posedge aclk) begin : check_bytes
        utf8_byte_t want;
        if (aresetn && m_valid && m_ready) begin
            if (utf8_expected.size() == 0) begin
                $display("%0t: byte with nothing expected: expected none, actual %02h final %0b",
                         $time, m_out_byte, m_final_byte);
                mismatches++;
            end else begin
                want = utf8_expected.pop_front();
                if (m_out_byte !== want.value) begin
                    $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                             $time, want.value, m_out_byte);
                    mismatches++;
                end
                if (m_final_byte !== want.last) begin
                    $display("%0t: final_byte mismatch: expected %0b, actual %0b",
                             $time, want.last, m_final_byte);
                    mismatches++;
                end
            end
        end
    end

    // A run in which no channel completes a transfer for too long is hung.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int   row;
        int   phase;
        int   setting;
        logic [7:0] cap;

        // Reset is held low from the start and then released for good.
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // The directed table runs with the first phase's idling.
        src_idle_pct  = 7;
        sink_idle_pct = 76;
        for (row = 0; row < DIRECTED_ROWS; row++) begin
            if (DIRECTED[row].kind == ROW_CFG) begin
                write_capacity(DIRECTED[row].unit[7:0]);
            end else begin
                push_item(DIRECTED[row].unit, DIRECTED[row].has, DIRECTED[row].eon,
                          DIRECTED[row].kind == ROW_LIT, DIRECTED[row].n_bytes,
                          DIRECTED[row].bytes);
            end
        end

        // Three idling phases, each with four capacity settings. A setting is
        // changed after each batch of items, once the block is idle, which often
        // falls in the middle of a name.
        units_left = next_name_length();
        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    src_idle_pct  = 7;
                    sink_idle_pct = 76;
                end
                1: begin
                    src_idle_pct  = 76;
                    sink_idle_pct = 7;
                end
                default: begin
                    src_idle_pct  = 0;
                    sink_idle_pct = 0;
                end
            endcase
            for (setting = 0; setting < 4; setting++) begin
                case (setting)
                    0:       cap = 8'd255;
                    1:       cap = 8'd1;
                    2:       cap = 8'($urandom_range(2, 20));
                    default: cap = 8'($urandom_range(1, 254));
                endcase
                write_capacity(cap);
                stream_names(ITEMS_PER_SETTING);
            end
        end

        // Let every owed byte arrive, then watch a little longer for strays.
        s_valid <= 1'b0;
        while (utf8_expected.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
